// ===== rtl/saw_arq_pkg.sv =====
`timescale 1ns / 1ps
package saw_arq_pkg;

  // Packet buffer geometry
  localparam int MAX_PACKET = 32;
  localparam int IDX_W      = $clog2(MAX_PACKET);
  localparam int CNT_W      = $clog2(MAX_PACKET + 1);

  // Payload starts after checksum, sequence and total bytes
  localparam logic [CNT_W-1:0] PAYLOAD_START = CNT_W'(3);

  // Item opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_CODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

  localparam logic [7:0]  REQUEST_CODE_RST  = 8'd48;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  // Result kinds
  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Frame letters
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_K = 8'h4B;

  // Frame byte positions
  localparam logic [2:0] FR_CHK  = 3'd0;
  localparam logic [2:0] FR_A    = 3'd1;
  localparam logic [2:0] FR_B    = 3'd2;
  localparam logic [2:0] FR_C    = 3'd3;
  localparam logic [2:0] FR_LAST = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] in_byte;
    logic       in_last;
  } item_word_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_byte;
    logic       out_last;
    logic       done_flag;
  } result_word_t;

  // One byte of a GET or ACK frame: checksum, three letters, then the tail byte
  function automatic logic [7:0] frame_byte(input logic is_ack, input logic [2:0] pos,
                                            input logic [7:0] tail);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] r;
    a = is_ack ? CH_A : CH_G;
    b = is_ack ? CH_C : CH_E;
    c = is_ack ? CH_K : CH_T;
    case (pos)
      FR_CHK:  r = a ^ b ^ c ^ tail;
      FR_A:    r = a;
      FR_B:    r = b;
      FR_C:    r = c;
      default: r = tail;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/stop_and_wait_arq_receiver.sv =====
`timescale 1ns / 1ps
// Stop-and-wait receiver. Packet bytes, timer ticks and ignored opcodes are taken
// one item at a time while idle; items stall while a frame or payload is emitted.
// A start item emits the GET frame. The last byte of a good packet delivers each
// payload byte if its sequence is the next one (the packet buffer is read once per
// byte, with a registered read), then emits the ACK frame; a timer expiry likewise
// emits a frame unless the transfer is done. Every emitted word also waits for
// result_stall to be low. Registers may be written only while the block is idle.
module stop_and_wait_arq_receiver import saw_arq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_word_t           item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_word_t         result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_DLV, S_FRAME} state_t;

  state_t           state;
  logic [7:0]       request_code;
  logic [15:0]      timeout_ticks;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       running_xor;
  logic             overflow_seen;
  logic [7:0]       accepted_seq;
  logic [15:0]      timer_count;
  logic             timer_armed;
  logic             transfer_done;
  logic [7:0]       seq_byte;
  logic [7:0]       total_byte;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] pay_end;
  logic [2:0]       frame_pos;
  logic             frame_ack;
  logic [7:0]       frame_tail;

  // Packet buffer
  logic [7:0]       mem [MAX_PACKET];
  logic [7:0]       rdata;
  logic             mem_we;
  logic             mem_re;

  logic             accept;
  logic             load_ok;
  logic [CNT_W-1:0] count_next;
  logic [7:0]       xor_next;
  logic             ovf_next;
  logic [7:0]       total_next;
  logic             pkt_ok;
  logic             seq_match;
  logic             done_next;
  logic [15:0]      tick_next;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);
  assign load_ok    = !result_valid || !result_stall;

  // Buffer write while bytes stream in, read while payload is delivered
  assign mem_we = accept && (item.opcode == OP_BYTE) && (byte_count < CNT_W'(MAX_PACKET));
  assign mem_re = (state == S_RD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[byte_count[IDX_W-1:0]] <= item.in_byte;
    end
    if (mem_re) begin
      rdata <= mem[ptr[IDX_W-1:0]];
    end
  end

  // Packet end evaluation, from the state as it stands after this byte
  always_comb begin
    count_next = mem_we ? byte_count + CNT_W'(1) : byte_count;
    xor_next   = running_xor ^ item.in_byte;
    ovf_next   = overflow_seen || (byte_count >= CNT_W'(MAX_PACKET));
    total_next = (byte_count == CNT_W'(2)) ? item.in_byte : total_byte;
    pkt_ok     = !ovf_next && (count_next >= PAYLOAD_START) && (xor_next == 8'd0);
    seq_match  = (seq_byte == 8'(accepted_seq + 8'd1));
    done_next  = transfer_done || (seq_match && (seq_byte == total_next));
    tick_next  = 16'(timer_count + 16'd1);
  end

  // Control, timer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      request_code  <= REQUEST_CODE_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
      byte_count    <= '0;
      running_xor   <= '0;
      overflow_seen <= 1'b0;
      accepted_seq  <= '0;
      timer_count   <= '0;
      timer_armed   <= 1'b0;
      transfer_done <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          REG_REQUEST_CODE:  request_code  <= cfg_data[7:0];
          REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.opcode)
              OP_START: begin
                frame_ack   <= 1'b0;
                frame_tail  <= request_code;
                frame_pos   <= FR_CHK;
                timer_armed <= 1'b1;
                timer_count <= '0;
                state       <= S_FRAME;
              end
              OP_BYTE: begin
                byte_count    <= count_next;
                running_xor   <= xor_next;
                overflow_seen <= ovf_next;
                if (mem_we && byte_count == CNT_W'(1)) begin
                  seq_byte <= item.in_byte;
                end
                if (mem_we && byte_count == CNT_W'(2)) begin
                  total_byte <= item.in_byte;
                end
                if (item.in_last) begin
                  // packet closes: reset the collector either way
                  byte_count    <= '0;
                  running_xor   <= '0;
                  overflow_seen <= 1'b0;
                  if (pkt_ok) begin
                    timer_armed   <= !done_next;
                    timer_count   <= '0;
                    transfer_done <= done_next;
                    frame_ack     <= 1'b1;
                    frame_tail    <= seq_byte;
                    frame_pos     <= FR_CHK;
                    pay_end       <= count_next;
                    ptr           <= PAYLOAD_START;
                    if (seq_match) begin
                      accepted_seq <= seq_byte;
                    end
                    if (seq_match && count_next > PAYLOAD_START) begin
                      state <= S_RD;
                    end else begin
                      state <= S_FRAME;
                    end
                  end
                end
              end
              OP_TICK: begin
                if (timer_armed) begin
                  if (tick_next >= timeout_ticks) begin
                    timer_count <= '0;
                    timer_armed <= !transfer_done;
                    if (!transfer_done) begin
                      frame_ack  <= (accepted_seq != 8'd0);
                      frame_tail <= (accepted_seq != 8'd0) ? accepted_seq : request_code;
                      frame_pos  <= FR_CHK;
                      state      <= S_FRAME;
                    end
                  end else begin
                    timer_count <= tick_next;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          state <= S_DLV;
        end
        S_DLV: begin
          if (load_ok) begin
            result_valid     <= 1'b1;
            result.out_kind  <= KIND_PAYLOAD;
            result.out_byte  <= rdata;
            result.out_last  <= 1'b0;
            result.done_flag <= transfer_done;
            if (ptr == pay_end - CNT_W'(1)) begin
              state <= S_FRAME;
            end else begin
              ptr   <= ptr + CNT_W'(1);
              state <= S_RD;
            end
          end
        end
        S_FRAME: begin
          if (load_ok) begin
            result_valid     <= 1'b1;
            result.out_kind  <= KIND_TX;
            result.out_byte  <= frame_byte(frame_ack, frame_pos, frame_tail);
            result.out_last  <= (frame_pos == FR_LAST);
            result.done_flag <= transfer_done;
            if (frame_pos == FR_LAST) begin
              state <= S_IDLE;
            end else begin
              frame_pos <= frame_pos + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
